// ----- design/wbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe_pkg: shared types and constants of the block encrypt unit
// S-box, nibble shuffle, round constant tables and the sequencer types.
// ----------------------------------------------------------------------------
package wbe_pkg;

  localparam int unsigned NibW     = 4;
  localparam int unsigned NibCount = 32;
  localparam int unsigned HalfNib  = 16;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned RndW     = 6;
  localparam int unsigned RcLen    = 41;
  localparam int unsigned MaxRoundsDef = 41;
  localparam logic [RndW-1:0] RoundsRst = 6'd41;

  typedef logic [NibCount-1:0][NibW-1:0] wbe_blk_t;
  typedef logic [HalfNib-1:0][NibW-1:0]  wbe_half_t;

  localparam logic [NibW-1:0] SBOX [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };

  localparam logic [4:0] PERM [NibCount] = '{
    5'd31, 5'd6,  5'd29, 5'd14, 5'd1,  5'd12, 5'd21, 5'd8,
    5'd27, 5'd2,  5'd3,  5'd0,  5'd25, 5'd4,  5'd23, 5'd10,
    5'd15, 5'd22, 5'd13, 5'd30, 5'd17, 5'd28, 5'd5,  5'd24,
    5'd11, 5'd18, 5'd19, 5'd16, 5'd9,  5'd20, 5'd7,  5'd26
  };

  localparam logic [NibW-1:0] RC0 [RcLen] = '{
    4'h0, 4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'hf, 4'hf, 4'he, 4'hd,
    4'ha, 4'h5, 4'ha, 4'h5, 4'hb, 4'h6, 4'hc, 4'h9, 4'h3, 4'h6,
    4'hd, 4'hb, 4'h7, 4'he, 4'hd, 4'hb, 4'h6, 4'hd, 4'ha, 4'h4,
    4'h9, 4'h2, 4'h4, 4'h9, 4'h3, 4'h7, 4'he, 4'hc, 4'h8, 4'h1, 4'h2
  };

  localparam logic [NibW-1:0] RC1 [RcLen] = '{
    4'h4, 4'hc, 4'hc, 4'hc, 4'hc, 4'hc, 4'h8, 4'h4, 4'h8, 4'h4,
    4'h8, 4'h4, 4'hc, 4'h8, 4'h0, 4'h4, 4'hc, 4'h8, 4'h4, 4'hc,
    4'hc, 4'h8, 4'h4, 4'hc, 4'h8, 4'h4, 4'h8, 4'h0, 4'h4, 4'h8,
    4'h0, 4'h4, 4'hc, 4'hc, 4'h8, 4'h0, 4'h0, 4'h4, 4'h8, 4'h4, 4'hc
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } wbe_state_e;

  // sequencer to datapath control
  typedef struct packed {
    logic            load;
    logic            step;
    logic [RndW-1:0] rnd;
  } wbe_ctl_t;

endpackage

`default_nettype wire

// ----- design/wbe_round.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe_round: one cipher round
// S-box and key mix into the odd nibbles, round constants, nibble shuffle.
// ----------------------------------------------------------------------------
module wbe_round (
  input  wbe_pkg::wbe_blk_t            st_i,
  input  wbe_pkg::wbe_half_t           key_i,
  input  logic [wbe_pkg::NibW-1:0]     rc0_i,
  input  logic [wbe_pkg::NibW-1:0]     rc1_i,
  output wbe_pkg::wbe_blk_t            st_o
);
  import wbe_pkg::*;

  wbe_blk_t mix;

  always_comb begin
    mix = st_i;
    for (int j = 0; j < HalfNib; j++) begin
      mix[2*j+1] = st_i[2*j+1] ^ SBOX[st_i[2*j]] ^ key_i[j];
    end
    mix[1] = mix[1] ^ rc0_i;
    mix[3] = mix[3] ^ rc1_i;
  end

  // shuffle: nibble i moves to PERM[i]
  always_comb begin
    st_o = '0;
    for (int i = 0; i < NibCount; i++) begin
      st_o[PERM[i]] = mix[i];
    end
  end

endmodule

`default_nettype wire

// ----- design/wbe_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe_seq: round sequencer
// Holds the round count register, counts rounds and drives the handshakes.
// ----------------------------------------------------------------------------
module wbe_seq #(
  parameter int unsigned MAX_ROUNDS = wbe_pkg::MaxRoundsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [wbe_pkg::RndW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output wbe_pkg::wbe_ctl_t        ctl_o
);
  import wbe_pkg::*;

  localparam int unsigned RndLimit = (MAX_ROUNDS < RcLen) ? MAX_ROUNDS : RcLen;
  localparam logic [RndW-1:0] LimitV = RndW'(RndLimit);

  wbe_state_e      state_q, state_d;
  logic [RndW-1:0] cfg_q;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [RndW-1:0] rounds_q, rounds_d;
  logic [RndW-1:0] rounds_sat;

  assign rounds_sat = (cfg_q > LimitV) ? LimitV : cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= RoundsRst;
      rnd_q    <= '0;
      rounds_q <= '0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      rounds_q <= rounds_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    rounds_d    = rounds_q;
    ctl_o.load  = 1'b0;
    ctl_o.step  = 1'b0;
    ctl_o.rnd   = rnd_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          rnd_d      = '0;
          rounds_d   = rounds_sat;
          // zero rounds: plaintext goes straight out
          state_d    = (rounds_sat == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        ctl_o.step = 1'b1;
        rnd_d      = rnd_q + RndW'(1);
        if (rnd_d == rounds_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/warp_block_encrypt_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// warp_block_encrypt_unit: 128-bit generalized-Feistel block encryption
// Iterative core: one shared round unit applied once per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o    | plain_low/high, key_low/high
//  out     | output    | out_valid_o / out_stall_i  | cipher_low/high
//  cfg     | input     | cfg_we_i (no wait)         | cfg_wdata_i = round_count
//
//  After accepting an input beat the core loads it, applies the single round unit
//  once per round for R rounds, with R the round count clipped to MAX_ROUNDS and
//  to the 41-entry constant table, and then presents the result.
//  Reset sets the round count to 41 and leaves the core idle.
//  A stalled output beat holds in the state register; no new beat is taken
//  until it has gone.
// ----------------------------------------------------------------------------
module warp_block_encrypt_unit #(
  parameter int unsigned MAX_ROUNDS = wbe_pkg::MaxRoundsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wbe_pkg::RndW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [wbe_pkg::HalfW-1:0] plain_low_i,
  input  logic [wbe_pkg::HalfW-1:0] plain_high_i,
  input  logic [wbe_pkg::HalfW-1:0] key_low_i,
  input  logic [wbe_pkg::HalfW-1:0] key_high_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [wbe_pkg::HalfW-1:0] cipher_low_o,
  output logic [wbe_pkg::HalfW-1:0] cipher_high_o
);
  import wbe_pkg::*;

  wbe_ctl_t  ctl;
  wbe_blk_t  st_q;
  wbe_blk_t  st_nxt;
  wbe_blk_t  key_q;
  wbe_half_t key_half;

  // sequencer: round count register, round counter, handshakes
  wbe_seq #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  // even rounds take the low key half, odd rounds the high half
  assign key_half = ctl.rnd[0] ? key_q[NibCount-1:HalfNib] : key_q[HalfNib-1:0];

  wbe_round u_round (
    .st_i  (st_q),
    .key_i (key_half),
    .rc0_i (RC0[ctl.rnd]),
    .rc1_i (RC1[ctl.rnd]),
    .st_o  (st_nxt)
  );

  // state and key registers: load on accept, advance one round per step
  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      st_q  <= {plain_high_i, plain_low_i};
      key_q <= {key_high_i, key_low_i};
    end else if (ctl.step) begin
      st_q <= st_nxt;
    end
  end

  // the state register doubles as the output register
  assign cipher_low_o  = st_q[HalfNib-1:0];
  assign cipher_high_o = st_q[NibCount-1:HalfNib];

endmodule

`default_nettype wire

// ----- tb/sv/warp_cipher_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// warp_cipher_checker: block encryption predictor and cipher beat checker
// Watches the configuration and both channels of the block encrypt unit.
// Encrypts every accepted plaintext beat with a local copy of the round count
// and compares each accepted cipher beat with the oldest expected one.
// ----------------------------------------------------------------------------
module warp_cipher_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wbe_pkg::RndW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [wbe_pkg::HalfW-1:0] plain_low_i,
  input  logic [wbe_pkg::HalfW-1:0] plain_high_i,
  input  logic [wbe_pkg::HalfW-1:0] key_low_i,
  input  logic [wbe_pkg::HalfW-1:0] key_high_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [wbe_pkg::HalfW-1:0] cipher_low_i,
  input  logic [wbe_pkg::HalfW-1:0] cipher_high_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int unsigned             ROUND_CAP       = 41;
  localparam logic [wbe_pkg::RndW-1:0] ROUNDS_AT_RESET = 6'd41;

  localparam logic [3:0] NIB_SUB [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };

  localparam logic [4:0] NIB_MOVE [32] = '{
    5'd31, 5'd6,  5'd29, 5'd14, 5'd1,  5'd12, 5'd21, 5'd8,
    5'd27, 5'd2,  5'd3,  5'd0,  5'd25, 5'd4,  5'd23, 5'd10,
    5'd15, 5'd22, 5'd13, 5'd30, 5'd17, 5'd28, 5'd5,  5'd24,
    5'd11, 5'd18, 5'd19, 5'd16, 5'd9,  5'd20, 5'd7,  5'd26
  };

  localparam logic [3:0] RCON_A [41] = '{
    4'h0, 4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'hf, 4'hf, 4'he, 4'hd,
    4'ha, 4'h5, 4'ha, 4'h5, 4'hb, 4'h6, 4'hc, 4'h9, 4'h3, 4'h6,
    4'hd, 4'hb, 4'h7, 4'he, 4'hd, 4'hb, 4'h6, 4'hd, 4'ha, 4'h4,
    4'h9, 4'h2, 4'h4, 4'h9, 4'h3, 4'h7, 4'he, 4'hc, 4'h8, 4'h1, 4'h2
  };

  localparam logic [3:0] RCON_B [41] = '{
    4'h4, 4'hc, 4'hc, 4'hc, 4'hc, 4'hc, 4'h8, 4'h4, 4'h8, 4'h4,
    4'h8, 4'h4, 4'hc, 4'h8, 4'h0, 4'h4, 4'hc, 4'h8, 4'h4, 4'hc,
    4'hc, 4'h8, 4'h4, 4'hc, 4'h8, 4'h4, 4'h8, 4'h0, 4'h4, 4'h8,
    4'h0, 4'h4, 4'hc, 4'hc, 4'h8, 4'h0, 4'h0, 4'h4, 4'h8, 4'h4, 4'hc
  };

  typedef struct {
    logic [wbe_pkg::HalfW-1:0] lo;
    logic [wbe_pkg::HalfW-1:0] hi;
  } cipher_beat_t;

  cipher_beat_t               expected_cipher_q [$];
  cipher_beat_t               oldest_cipher;
  wbe_pkg::wbe_blk_t          encrypted;
  logic [wbe_pkg::RndW-1:0]   round_setting;
  int                         mismatches;

  // Encrypt one block; counts above the table length saturate.
  function automatic wbe_pkg::wbe_blk_t warp_encrypt(input wbe_pkg::wbe_blk_t plain,
                                                     input wbe_pkg::wbe_blk_t key,
                                                     input logic [wbe_pkg::RndW-1:0] rounds);
    wbe_pkg::wbe_blk_t st;
    wbe_pkg::wbe_blk_t moved;
    int unsigned       n;
    logic [3:0]        f;
    n  = (rounds > ROUND_CAP) ? ROUND_CAP : rounds;
    st = plain;
    for (int r = 0; r < n; r++) begin
      for (int j = 0; j < 16; j++) begin
        f             = NIB_SUB[st[2*j]] ^ key[(r % 2) * 16 + j];
        st[2*j + 1]   = st[2*j + 1] ^ f;
      end
      st[1] = st[1] ^ RCON_A[r];
      st[3] = st[3] ^ RCON_B[r];
      for (int i = 0; i < 32; i++) begin
        moved[NIB_MOVE[i]] = st[i];
      end
      st = moved;
    end
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_setting = ROUNDS_AT_RESET;
      expected_cipher_q.delete();
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        encrypted = warp_encrypt({plain_high_i, plain_low_i}, {key_high_i, key_low_i},
                                 round_setting);
        oldest_cipher.lo = encrypted[15:0];
        oldest_cipher.hi = encrypted[31:16];
        expected_cipher_q.push_back(oldest_cipher);
      end
      if (cfg_we_i) begin
        round_setting = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_cipher_q.size() == 0) begin
          $error("cipher beat with no block outstanding: low %h high %h",
                 cipher_low_i, cipher_high_i);
          mismatches++;
        end else begin
          oldest_cipher = expected_cipher_q.pop_front();
          if (cipher_low_i !== oldest_cipher.lo) begin
            $error("cipher_low: expected %h, got %h", oldest_cipher.lo, cipher_low_i);
            mismatches++;
          end
          if (cipher_high_i !== oldest_cipher.hi) begin
            $error("cipher_high: expected %h, got %h", oldest_cipher.hi, cipher_high_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_cipher_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_warp_block_encrypt_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_warp_block_encrypt_unit: stimulus and verdict for the block encrypt unit
// Drives directed and random plaintext/key beats over a range of round
// counts, with random idling on both channels; the checker beside the block
// predicts every cipher beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_warp_block_encrypt_unit;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam int          PHASES   = 14;
  localparam int          PHASE_BLOCKS = 100;
  localparam int          HOLD_CYCLES  = 400;

  // Round counts visited first: reset value, none, saturating, single, edges.
  localparam logic [5:0]  ROUND_EXTREMES [7] = '{6'd41, 6'd0, 6'd63, 6'd1, 6'd40, 6'd42, 6'd2};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [5:0]  cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [63:0] plain_low  = '0;
  logic [63:0] plain_high = '0;
  logic [63:0] key_low    = '0;
  logic [63:0] key_high   = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;
  int          fail_count;
  int          pending;

  // Set by the stimulus, read by the receiver process.
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;

  always #5 clk = ~clk;

  warp_block_encrypt_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .plain_low_i   (plain_low),
    .plain_high_i  (plain_high),
    .key_low_i     (key_low),
    .key_high_i    (key_high),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .cipher_low_o  (cipher_low),
    .cipher_high_o (cipher_high)
  );

  warp_cipher_checker cipher_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .plain_low_i   (plain_low),
    .plain_high_i  (plain_high),
    .key_low_i     (key_low),
    .key_high_i    (key_high),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .cipher_low_i  (cipher_low),
    .cipher_high_i (cipher_high),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mostly dense random halves, with the odd all-zero, all-one or one-hot word.
  function automatic logic [63:0] random_half();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       return '0;
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one beat and hold it until the block takes it. A random gap may
  // come first; valid drops only for the gap, never within a step.
  task automatic send_block(input logic [63:0] p_lo, input logic [63:0] p_hi,
                            input logic [63:0] k_lo, input logic [63:0] k_hi);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    plain_low  <= p_lo;
    plain_high <= p_hi;
    key_low    <= k_lo;
    key_high   <= k_hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_block();
    send_block(random_half(), random_half(), random_half(), random_half());
  endtask

  // Drop valid and wait until every outstanding cipher beat has come back.
  // The checker count lags the edge by one step, hence the first wait.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the round count; only ever called with the block idle.
  task automatic write_rounds(input logic [5:0] rounds);
    cfg_we    <= 1'b1;
    cfg_wdata <= rounds;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stall bursts, a long hold-off on request, none when quiet.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [5:0] rounds;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full 41 rounds from reset: extremes of plaintext and key.
    send_block('0, '0, '0, '0);
    send_block(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_block(ALL_ONES, ALL_ONES, '0, '0);
    send_block('0, '0, ALL_ONES, ALL_ONES);
    send_block(64'hfedc_ba98_7654_3210, 64'h0123_4567_89ab_cdef,
               64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);

    // No rounds at all: the cipher beat must equal the plaintext.
    settle();
    write_rounds(6'd0);
    send_random_block();
    send_block(ALL_ONES, 64'h8000_0000_0000_0001, ALL_ONES, '0);

    // Counts beyond the constant table saturate at the full cipher.
    settle();
    write_rounds(6'd63);
    send_random_block();
    send_block('0, '0, '0, '0);
    settle();
    write_rounds(6'd42);
    send_random_block();

    // One round uses the low key only, two rounds bring in the high key.
    settle();
    write_rounds(6'd1);
    send_block('0, '0, '0, ALL_ONES);
    send_block('0, '0, ALL_ONES, '0);
    settle();
    write_rounds(6'd2);
    send_block('0, '0, '0, ALL_ONES);

    // Random phases, each with its own round count; the last without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      rounds = (phase < 7) ? ROUND_EXTREMES[phase] : 6'($urandom_range(0, 63));
      write_rounds(rounds);
      if (phase == PHASES - 1) begin
        quiet = 1'b1;
      end
      for (int k = 0; k < PHASE_BLOCKS; k++) begin
        // Long receiver hold-off with the sender still offering: fill the block.
        if (phase == 2 && k == 30) begin
          hold_req = 1'b1;
        end
        // Sender pause until the block has drained completely.
        if (phase == 4 && k == 50) begin
          settle();
        end
        send_random_block();
      end
    end

    settle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** warp_block_encrypt_unit: PASSED **");
    end else begin
      $display("** warp_block_encrypt_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("** warp_block_encrypt_unit: FAILED **");
    $finish;
  end

endmodule
